// File: rtl/ps2md_pkg.sv
// Package for the PS/2 mouse packet decoder: field constants and result type.
package ps2md_pkg;

    localparam int ByteW   = 8;
    localparam int PosW    = 32;
    localparam int IdxW    = 2;
    localparam int BtnW    = 3;
    localparam int OutPadW = 5;

    // Header byte bit positions
    localparam int HdrAlways = 3;
    localparam int HdrXSign  = 4;
    localparam int HdrYSign  = 5;
    localparam int HdrXOvf   = 6;
    localparam int HdrYOvf   = 7;

    localparam logic [ByteW-1:0] ExtraBadMask = 8'hC0;
    localparam logic [PosW-1:0]  SignFill     = 32'hFFFF_FF00;

    localparam logic [IdxW-1:0] IdxHead  = 2'd0;
    localparam logic [IdxW-1:0] IdxDy    = 2'd2;
    localparam logic [IdxW-1:0] IdxExtra = 2'd3;

    typedef struct packed {
        logic [BtnW-1:0] buttons;   // bit0 left, bit1 right, bit2 middle
        logic [PosW-1:0] pos_y;
        logic [PosW-1:0] pos_x;
    } t_result;

endpackage

// File: rtl/ps2md_core.sv
// Packet assembly, validity checks and position/button accumulation.
module ps2md_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [ps2md_pkg::ByteW-1:0]    i_byte,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_mode,
    output logic                           o_res_valid,
    output ps2md_pkg::t_result             o_res
);

    logic                          r_mode;
    logic [ps2md_pkg::IdxW-1:0]    r_idx;
    logic [ps2md_pkg::ByteW-1:0]   r_pkt [3];
    logic [ps2md_pkg::PosW-1:0]    r_acc_x;
    logic [ps2md_pkg::PosW-1:0]    r_acc_y;
    logic [ps2md_pkg::BtnW-1:0]    r_btn;

    logic [ps2md_pkg::IdxW-1:0]    n_idx;
    logic [ps2md_pkg::IdxW-1:0]    last_idx;
    logic                          take;
    logic                          finish;
    logic                          bad;
    logic                          changed;
    logic [ps2md_pkg::ByteW-1:0]   head;
    logic [ps2md_pkg::ByteW-1:0]   dy_byte;
    logic [ps2md_pkg::PosW-1:0]    dx;
    logic [ps2md_pkg::PosW-1:0]    dy;
    logic [ps2md_pkg::PosW-1:0]    nx;
    logic [ps2md_pkg::PosW-1:0]    ny;
    logic [ps2md_pkg::BtnW-1:0]    nb;

    always_comb begin
        last_idx = r_mode ? ps2md_pkg::IdxExtra : ps2md_pkg::IdxDy;
        take     = i_step && ((r_idx != ps2md_pkg::IdxHead) || i_byte[ps2md_pkg::HdrAlways]);
        finish   = take && (r_idx >= last_idx);
        head     = r_pkt[0];
        dy_byte  = (r_idx == ps2md_pkg::IdxDy) ? i_byte : r_pkt[2];
        dx       = {{(ps2md_pkg::PosW-ps2md_pkg::ByteW){1'b0}}, r_pkt[1]};
        dy       = {{(ps2md_pkg::PosW-ps2md_pkg::ByteW){1'b0}}, dy_byte};
        if (head[ps2md_pkg::HdrXSign]) begin
            dx = dx | ps2md_pkg::SignFill;
        end
        if (head[ps2md_pkg::HdrYSign]) begin
            dy = dy | ps2md_pkg::SignFill;
        end
        nx      = r_acc_x + dx;
        ny      = r_acc_y - dy;
        nb      = head[ps2md_pkg::BtnW-1:0];
        bad     = (r_mode && ((i_byte & ps2md_pkg::ExtraBadMask) != '0))
                  || head[ps2md_pkg::HdrXOvf] || head[ps2md_pkg::HdrYOvf];
        changed = (nx != r_acc_x) || (ny != r_acc_y) || (nb != r_btn);
        o_res_valid = finish && !bad && changed;
        o_res.pos_x   = nx;
        o_res.pos_y   = ny;
        o_res.buttons = nb;
        if (finish) begin
            n_idx = ps2md_pkg::IdxHead;
        end else if (take) begin
            n_idx = r_idx + 2'd1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_idx   <= ps2md_pkg::IdxHead;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_btn   <= '0;
            r_pkt[0] <= '0;
            r_pkt[1] <= '0;
            r_pkt[2] <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_mode;
                r_idx  <= ps2md_pkg::IdxHead;
            end else begin
                r_idx <= n_idx;
            end
            if (take && (r_idx != ps2md_pkg::IdxExtra)) begin
                r_pkt[r_idx] <= i_byte;
            end
            if (o_res_valid) begin
                r_acc_x <= nx;
                r_acc_y <= ny;
                r_btn   <= nb;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(!r_mode && (r_idx == ps2md_pkg::IdxExtra)))
        else $error("byte index past packet end in three-byte mode");

    a_res_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_idx == ps2md_pkg::IdxHead))
        else $error("packet index not restarted after result");

    a_res_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_acc_x != $past(r_acc_x) || r_acc_y != $past(r_acc_y)
                         || r_btn != $past(r_btn)))
        else $error("result given without a change");

    a_quiet_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res_valid |=> ($stable(r_acc_x) && $stable(r_acc_y) && $stable(r_btn)))
        else $error("state changed without a result");
`endif

endmodule

// File: rtl/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse packet decoder with stream ports.
// A result reaches the master side after its last byte is registered in r_in_byte and the result in r_out.
// Throughput: one byte per cycle; s_axis_tready drops only while a result waits and a byte is held.
// A packet with no change, overflow or a bad fourth byte produces no item.
// Reset (synchronous, active low) clears mode, packet index, positions and buttons.
module ps2_mouse_packet_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] pos_x, [63:32] pos_y, [64] left_down,
                                        // [65] right_down, [66] middle_down, rest zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data      // [0] four_byte_mode
);

    logic                          r_in_valid;
    logic [ps2md_pkg::ByteW-1:0]   r_in_byte;
    logic                          r_out_valid;
    ps2md_pkg::t_result            r_out;

    logic                          out_free;
    logic                          step;
    logic                          res_valid;
    ps2md_pkg::t_result            res;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign o_cfg_ready   = 1'b1;

    ps2md_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_mode  (i_cfg_data[0]),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= step && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{ps2md_pkg::OutPadW{1'b0}}, r_out.buttons, r_out.pos_y, r_out.pos_x};

endmodule
